### rtl/core/dsm_pkg.sv
// Package for the decimal schoolbook multiplier: item structs, constants,
// microcode control word types and the microcode program table.
// Depends on nothing; used by decimal_schoolbook_multiplier.
package dsm_pkg;

	localparam int OPERAND_W = 31;
	localparam int DIGIT_W   = 4;
	localparam int STORE_W   = 5;
	localparam int MAC_W     = 7;
	localparam int RADIX     = 10;

	// Reciprocal of ten for 32-bit values: q = (v * RECIP_10) >> RECIP_SHIFT
	localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;
	localparam int          RECIP_SHIFT = 35;
	localparam int          DIV_PROD_W  = OPERAND_W + 32;

	// Reciprocal of ten for narrow column sums (exact below 1024)
	localparam logic [7:0] RECIP_10_NARROW = 8'd205;
	localparam int         NARROW_SHIFT    = 11;

	typedef struct packed {
		logic [OPERAND_W-1:0] operand_a;
		logic [OPERAND_W-1:0] operand_b;
	} in_t;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} out_t;

	// Datapath operation selected by a control word
	typedef enum logic [3:0] {
		OP_NOP,
		OP_DIV_A,
		OP_STORE_A,
		OP_DIV_B,
		OP_STORE_B,
		OP_MUL,
		OP_NORM,
		OP_ROW_END,
		OP_SET_LEN,
		OP_TRIM,
		OP_EMIT
	} op_t;

	// Jump condition: taken goes to the target, else to the next step
	typedef enum logic [3:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_NO_START,
		COND_ZERO,
		COND_A_MORE,
		COND_B_MORE,
		COND_J_MORE,
		COND_I_MORE,
		COND_TRIM,
		COND_EMIT_MORE
	} cond_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	// Step addresses of the program
	localparam step_t S_IDLE    = 4'd0;
	localparam step_t S_CHECK   = 4'd1;
	localparam step_t S_DIV_A   = 4'd2;
	localparam step_t S_STORE_A = 4'd3;
	localparam step_t S_DIV_B   = 4'd4;
	localparam step_t S_STORE_B = 4'd5;
	localparam step_t S_MUL     = 4'd6;
	localparam step_t S_NORM    = 4'd7;
	localparam step_t S_ROW     = 4'd8;
	localparam step_t S_LEN     = 4'd9;
	localparam step_t S_TRIM    = 4'd10;
	localparam step_t S_EMIT    = 4'd11;
	localparam step_t S_DONE    = 4'd12;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctl_t;

	// Microcode program table
	function automatic ctl_t ucode(input step_t step);
		ctl_t w;
		case (step)
			S_IDLE:    w = '{op: OP_NOP,     cond: COND_NO_START,  target: S_IDLE};
			S_CHECK:   w = '{op: OP_NOP,     cond: COND_ZERO,      target: S_EMIT};
			S_DIV_A:   w = '{op: OP_DIV_A,   cond: COND_NEVER,     target: S_IDLE};
			S_STORE_A: w = '{op: OP_STORE_A, cond: COND_A_MORE,    target: S_DIV_A};
			S_DIV_B:   w = '{op: OP_DIV_B,   cond: COND_NEVER,     target: S_IDLE};
			S_STORE_B: w = '{op: OP_STORE_B, cond: COND_B_MORE,    target: S_DIV_B};
			S_MUL:     w = '{op: OP_MUL,     cond: COND_NEVER,     target: S_IDLE};
			S_NORM:    w = '{op: OP_NORM,    cond: COND_J_MORE,    target: S_MUL};
			S_ROW:     w = '{op: OP_ROW_END, cond: COND_I_MORE,    target: S_MUL};
			S_LEN:     w = '{op: OP_SET_LEN, cond: COND_NEVER,     target: S_IDLE};
			S_TRIM:    w = '{op: OP_TRIM,    cond: COND_TRIM,      target: S_TRIM};
			S_EMIT:    w = '{op: OP_EMIT,    cond: COND_EMIT_MORE, target: S_EMIT};
			S_DONE:    w = '{op: OP_NOP,     cond: COND_ALWAYS,    target: S_IDLE};
			default:   w = '{op: OP_NOP,     cond: COND_ALWAYS,    target: S_IDLE};
		endcase
		return w;
	endfunction

	// Tens of a column sum below one hundred
	function automatic logic [DIGIT_W-1:0] div10_narrow(input logic [MAC_W-1:0] v);
		logic [MAC_W+7:0] p;
		p = {8'd0, v} * {{MAC_W{1'b0}}, RECIP_10_NARROW};
		return DIGIT_W'(p >> NARROW_SHIFT);
	endfunction

endpackage

### rtl/core/decimal_schoolbook_multiplier.sv
// Decimal schoolbook multiplier, top level: microcoded sequencer and datapath.
// Depends on dsm_pkg for item structs, control word types and the program.
//
// Raise start while busy is low to hand over one item (two 31-bit operands).
// The product comes out as decimal digits, most significant first, no
// leading zeros, one digit per strobe cycle with last on the final digit; a
// zero operand gives the single digit 0. The receiver cannot stall: each
// digit is valid, with strobe high, for exactly one cycle. busy stays high from
// the accepting edge until the last digit has been shown. An item's run time is
// set by the digit product loop: one shared 4x4 digit multiplier visited in
// two steps per digit pair, one product store read port.
module decimal_schoolbook_multiplier #(
	parameter int OPERAND_DIGITS = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  dsm_pkg::in_t   operands,
	output logic           strobe,
	output dsm_pkg::out_t  result
);

	localparam int PRODUCT_DIGITS = 2 * OPERAND_DIGITS;
	localparam int IW = $clog2(OPERAND_DIGITS);
	localparam int CW = $clog2(OPERAND_DIGITS + 1);
	localparam int PW = $clog2(PRODUCT_DIGITS);
	localparam int LW = $clog2(PRODUCT_DIGITS + 1);

	// Sequencer
	dsm_pkg::step_t pc_q;
	dsm_pkg::step_t pc_next;
	dsm_pkg::ctl_t  ctl;
	logic           jump;
	logic           accept;

	// Datapath storage
	logic [dsm_pkg::OPERAND_W-1:0]  val_a_q;
	logic [dsm_pkg::OPERAND_W-1:0]  val_b_q;
	logic [dsm_pkg::DIV_PROD_W-1:0] div_prod_q;
	logic [dsm_pkg::DIGIT_W-1:0]    digits_a_q [OPERAND_DIGITS];
	logic [dsm_pkg::DIGIT_W-1:0]    digits_b_q [OPERAND_DIGITS];
	logic [dsm_pkg::STORE_W-1:0]    product_q  [PRODUCT_DIGITS];
	logic [CW-1:0]                  count_a_q;
	logic [CW-1:0]                  count_b_q;
	logic [IW-1:0]                  i_q;
	logic [IW-1:0]                  j_q;
	logic [dsm_pkg::DIGIT_W-1:0]    carry_q;
	logic [dsm_pkg::MAC_W-1:0]      mac_q;
	logic [LW-1:0]                  len_q;
	logic                           zero_q;
	dsm_pkg::out_t                  result_q;
	logic                           strobe_q;

	// Derived datapath signals
	logic [dsm_pkg::OPERAND_W-1:0] div_src;
	logic [dsm_pkg::OPERAND_W-1:0] quot;
	logic [dsm_pkg::OPERAND_W-1:0] quot_x10;
	logic [dsm_pkg::DIGIT_W-1:0]   rem;
	logic [PW-1:0]                 k_idx;
	logic [PW-1:0]                 top_idx;
	logic [PW-1:0]                 rd_idx;
	logic [dsm_pkg::STORE_W-1:0]   rd_data;
	logic [dsm_pkg::DIGIT_W-1:0]   mac_tens;
	logic [dsm_pkg::DIGIT_W-1:0]   mac_units;
	logic [dsm_pkg::MAC_W-1:0]     mac_sum;
	logic                          a_more;
	logic                          b_more;
	logic                          j_more;
	logic                          i_more;
	logic                          trim_more;
	logic                          emit_more;

	assign ctl    = dsm_pkg::ucode(pc_q);
	assign busy   = (pc_q != dsm_pkg::S_IDLE);
	assign accept = start && !busy;
	assign strobe = strobe_q;
	assign result = result_q;

	// Divide by ten: quotient from the registered reciprocal product
	assign div_src  = (ctl.op == dsm_pkg::OP_DIV_B) ? val_b_q : val_a_q;
	assign quot     = dsm_pkg::OPERAND_W'(div_prod_q >> dsm_pkg::RECIP_SHIFT);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem      = (ctl.op == dsm_pkg::OP_STORE_B) ?
	                  dsm_pkg::DIGIT_W'(val_b_q - quot_x10) :
	                  dsm_pkg::DIGIT_W'(val_a_q - quot_x10);

	// Product store addressing: one read port
	assign k_idx   = PW'(i_q) + PW'(j_q);
	assign top_idx = PW'(i_q) + PW'(count_a_q);
	assign rd_idx  = (ctl.op == dsm_pkg::OP_MUL) ? k_idx : PW'(len_q - LW'(1));
	assign rd_data = product_q[rd_idx];

	// Column arithmetic
	assign mac_sum = dsm_pkg::MAC_W'(digits_a_q[j_q]) * dsm_pkg::MAC_W'(digits_b_q[i_q])
	               + dsm_pkg::MAC_W'(rd_data) + dsm_pkg::MAC_W'(carry_q);
	assign mac_tens  = dsm_pkg::div10_narrow(mac_q);
	assign mac_units = dsm_pkg::DIGIT_W'(mac_q - ((dsm_pkg::MAC_W'(mac_tens) << 3)
	                 + (dsm_pkg::MAC_W'(mac_tens) << 1)));

	// Loop conditions
	assign a_more    = (quot != '0) && ((count_a_q + CW'(1)) < CW'(OPERAND_DIGITS));
	assign b_more    = (quot != '0) && ((count_b_q + CW'(1)) < CW'(OPERAND_DIGITS));
	assign j_more    = (CW'(j_q) + CW'(1)) < count_a_q;
	assign i_more    = (CW'(i_q) + CW'(1)) < count_b_q;
	assign trim_more = (len_q > LW'(1)) && (rd_data == '0);
	assign emit_more = (len_q != LW'(1));

	// Jump decode
	always_comb begin
		case (ctl.cond)
			dsm_pkg::COND_NEVER:     jump = 1'b0;
			dsm_pkg::COND_ALWAYS:    jump = 1'b1;
			dsm_pkg::COND_NO_START:  jump = !start;
			dsm_pkg::COND_ZERO:      jump = zero_q;
			dsm_pkg::COND_A_MORE:    jump = a_more;
			dsm_pkg::COND_B_MORE:    jump = b_more;
			dsm_pkg::COND_J_MORE:    jump = j_more;
			dsm_pkg::COND_I_MORE:    jump = i_more;
			dsm_pkg::COND_TRIM:      jump = trim_more;
			dsm_pkg::COND_EMIT_MORE: jump = emit_more;
			default:                 jump = 1'b1;
		endcase
		pc_next = jump ? ctl.target : pc_q + dsm_pkg::STEP_W'(1);
	end

	// Step counter and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q     <= dsm_pkg::S_IDLE;
			strobe_q <= 1'b0;
		end else begin
			pc_q     <= pc_next;
			strobe_q <= (ctl.op == dsm_pkg::OP_EMIT);
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			val_a_q   <= operands.operand_a;
			val_b_q   <= operands.operand_b;
			zero_q    <= (operands.operand_a == '0) || (operands.operand_b == '0);
			count_a_q <= '0;
			count_b_q <= '0;
			i_q       <= '0;
			j_q       <= '0;
			carry_q   <= '0;
			len_q     <= LW'(1);
			for (int n = 0; n < PRODUCT_DIGITS; n++) begin
				product_q[n] <= '0;
			end
		end
		case (ctl.op)
			dsm_pkg::OP_DIV_A, dsm_pkg::OP_DIV_B: begin
				div_prod_q <= {32'd0, div_src} * {{dsm_pkg::OPERAND_W{1'b0}}, dsm_pkg::RECIP_10};
			end
			dsm_pkg::OP_STORE_A: begin
				digits_a_q[count_a_q[IW-1:0]] <= rem;
				val_a_q   <= quot;
				count_a_q <= count_a_q + CW'(1);
			end
			dsm_pkg::OP_STORE_B: begin
				digits_b_q[count_b_q[IW-1:0]] <= rem;
				val_b_q   <= quot;
				count_b_q <= count_b_q + CW'(1);
			end
			dsm_pkg::OP_MUL: begin
				mac_q <= mac_sum;
			end
			dsm_pkg::OP_NORM: begin
				product_q[k_idx] <= dsm_pkg::STORE_W'(mac_units);
				carry_q          <= mac_tens;
				if (j_more) begin
					j_q <= j_q + IW'(1);
				end
			end
			dsm_pkg::OP_ROW_END: begin
				product_q[top_idx] <= dsm_pkg::STORE_W'(carry_q);
				carry_q            <= '0;
				j_q                <= '0;
				if (i_more) begin
					i_q <= i_q + IW'(1);
				end
			end
			dsm_pkg::OP_SET_LEN: begin
				len_q <= LW'(count_a_q) + LW'(count_b_q);
			end
			dsm_pkg::OP_TRIM: begin
				if (trim_more) begin
					len_q <= len_q - LW'(1);
				end
			end
			dsm_pkg::OP_EMIT: begin
				result_q.digit <= rd_data[dsm_pkg::DIGIT_W-1:0];
				result_q.last  <= (len_q == LW'(1));
				len_q          <= len_q - LW'(1);
			end
			default: begin
			end
		endcase
	end

endmodule
